### hw/rtl/rmsn_pkg.sv
package rmsn_pkg;

    localparam int STORE_DEPTH     = 64;
    localparam int ADDR_W          = 6;
    localparam int SUM_W           = 37;
    localparam int CNT_W           = 7;
    localparam int DEFAULT_MAX_LEN = 64;
    localparam int EPS_W           = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
    localparam int OFIFO_DEPTH     = 4;

    // One closed vector handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] n;
        logic             bank;
    } t_job;

    typedef struct packed {
        logic            en;
        logic [ADDR_W:0] addr;   // bank bit on top
    } t_rd_req;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] w;
    } t_rd_data;

    typedef struct packed {
        logic [15:0]       y;
        logic [ADDR_W-1:0] idx;
        logic              last;
    } t_res;

endpackage

### hw/rtl/rmsn_front.sv
module rmsn_front
    import rmsn_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_x,
    input  logic [15:0] i_w,
    input  logic        i_last,
    output t_job        o_job,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    input  logic        i_done,
    input  t_rd_req     i_rd_req,
    output t_rd_data    o_rd_data
);

    logic [15:0]      r_x_store [2*STORE_DEPTH];
    logic [15:0]      r_w_store [2*STORE_DEPTH];
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_bank;
    logic [1:0]       r_pending;
    logic [1:0]       n_pending;
    logic [15:0]      r_rd_x;
    logic [15:0]      r_rd_w;

    logic signed [31:0] sq;
    logic [SUM_W-1:0]   sum_nx;
    logic [CNT_W-1:0]   cnt_nx;
    logic               acc;
    logic               close;

    // Each bank holds one vector; at most two vectors may be open between
    // loading and the end of their read-out.
    assign o_ready = (r_pending != 2'd2) && i_job_ready;
    assign acc     = i_valid && o_ready;
    assign sq      = $signed(i_x) * $signed(i_x);
    assign sum_nx  = r_sum + SUM_W'(sq[30:0]);
    assign cnt_nx  = r_cnt + CNT_W'(1);
    assign close   = acc && (i_last || (cnt_nx == CNT_W'(MAX_LEN)));

    assign o_job_valid = close;
    assign o_job.sum   = sum_nx;
    assign o_job.n     = cnt_nx;
    assign o_job.bank  = r_bank;

    always_comb begin
        n_pending = r_pending;
        if (close && !i_done) begin
            n_pending = r_pending + 2'd1;
        end else if (!close && i_done) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_cnt     <= '0;
            r_bank    <= 1'b0;
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
            if (close) begin
                r_sum  <= '0;
                r_cnt  <= '0;
                r_bank <= ~r_bank;
            end else if (acc) begin
                r_sum <= sum_nx;
                r_cnt <= cnt_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_x_store[{r_bank, r_cnt[ADDR_W-1:0]}] <= i_x;
            r_w_store[{r_bank, r_cnt[ADDR_W-1:0]}] <= i_w;
        end
        if (i_rd_req.en) begin
            r_rd_x <= r_x_store[i_rd_req.addr];
            r_rd_w <= r_w_store[i_rd_req.addr];
        end
    end

    assign o_rd_data.x = r_rd_x;
    assign o_rd_data.w = r_rd_w;

endmodule

### hw/rtl/rmsn_queue.sv
module rmsn_queue
    import rmsn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_valid,
    output logic o_ready,
    output t_job o_job,
    output logic o_valid,
    input  logic i_ready
);

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (!push && pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

### hw/rtl/rmsn_back.sv
module rmsn_back
    import rmsn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [EPS_W-1:0] i_epsilon,
    input  t_job             i_job,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    output t_rd_req          o_rd_req,
    input  t_rd_data         i_rd_data,
    output logic             o_done,
    output t_res             o_res,
    output logic             o_valid,
    input  logic             i_ready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV1 = 3'd1;
    localparam logic [2:0] ST_DIV2 = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int QUO_W = 49;
    localparam int RT_W  = 25;

    logic [2:0]        r_state;
    logic [5:0]        r_cnt;
    logic [QUO_W-1:0]  r_quo;
    logic [SUM_W-1:0]  r_dvs;
    logic [SUM_W-1:0]  r_rem;
    logic [49:0]       r_sqv;
    logic [25:0]       r_srem;
    logic [RT_W-1:0]   r_root;
    logic [RT_W-1:0]   r_scale;
    logic [CNT_W-1:0]  r_n;
    logic              r_bank;
    logic [ADDR_W-1:0] r_j;

    // Restoring divider step, one quotient bit per cycle.
    logic [SUM_W:0]   rem_sh;
    logic             div_ge;
    logic [SUM_W:0]   rem_sub;
    logic [SUM_W-1:0] div_rem;
    logic [QUO_W-1:0] div_quo;
    logic [SUM_W:0]   m_sum;
    logic [SUM_W-1:0] m_val;

    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign div_rem = div_ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
    assign div_quo = {r_quo[QUO_W-2:0], div_ge};
    assign m_sum   = {1'b0, div_quo[SUM_W-1:0]} + (SUM_W+1)'(i_epsilon);
    assign m_val   = (m_sum[SUM_W-1:0] == '0) ? SUM_W'(1) : m_sum[SUM_W-1:0];

    // Square root step, two radicand bits and one root bit per cycle.
    logic [27:0]     srem_sh;
    logic [27:0]     trial;
    logic            sq_ge;
    logic [27:0]     srem_sub;
    logic [25:0]     sq_rem;
    logic [RT_W-1:0] root_nx;

    assign srem_sh  = {r_srem, r_sqv[49:48]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign sq_ge    = srem_sh >= trial;
    assign srem_sub = srem_sh - trial;
    assign sq_rem   = sq_ge ? srem_sub[25:0] : srem_sh[25:0];
    assign root_nx  = {r_root[RT_W-2:0], sq_ge};

    // Read-out pipeline: memory read, scale multiply, weight multiply, clamp.
    logic              r_va;
    logic [ADDR_W-1:0] r_idx_a;
    logic              r_last_a;
    logic              r_vb;
    logic [40:0]       r_p1_b;
    logic [15:0]       r_w_b;
    logic [ADDR_W-1:0] r_idx_b;
    logic              r_last_b;
    logic              r_vc;
    logic [40:0]       r_p2_c;
    logic [ADDR_W-1:0] r_idx_c;
    logic              r_last_c;

    logic signed [41:0] p1_full;
    logic signed [40:0] p2_full;
    logic signed [26:0] y_wide;
    logic [15:0]        y_sat;

    assign p1_full = $signed({1'b0, r_scale}) * $signed(i_rd_data.x);
    assign p2_full = $signed(r_p1_b[40:16]) * $signed(r_w_b);
    assign y_wide  = $signed(r_p2_c[40:14]);

    always_comb begin
        if (y_wide > 27'sd32767) begin
            y_sat = 16'h7FFF;
        end else if (y_wide < -27'sd32768) begin
            y_sat = 16'h8000;
        end else begin
            y_sat = y_wide[15:0];
        end
    end

    // Result queue; an element is only read when a place for it is sure.
    t_res       r_of_mem [OFIFO_DEPTH];
    logic [1:0] r_of_wr;
    logic [1:0] r_of_rd;
    logic [2:0] r_ocnt;
    logic [2:0] inflight;
    logic       credit_ok;
    logic       issue;
    logic       last_j;
    logic       push;
    logic       pop;
    t_res       res_in;

    assign inflight  = 3'(r_va) + 3'(r_vb) + 3'(r_vc);
    assign credit_ok = (r_ocnt + inflight) < 3'(OFIFO_DEPTH);
    assign issue     = (r_state == ST_EMIT) && credit_ok;
    assign last_j    = ({1'b0, r_j} + CNT_W'(1)) == r_n;
    assign push      = r_vc;
    assign pop       = o_valid && i_ready;

    assign res_in.y    = y_sat;
    assign res_in.idx  = r_idx_c;
    assign res_in.last = r_last_c;

    assign o_rd_req.en   = issue;
    assign o_rd_req.addr = {r_bank, r_j};
    assign o_done        = issue && last_j;
    assign o_job_ready   = (r_state == ST_IDLE);
    assign o_valid       = (r_ocnt != 3'd0);
    assign o_res         = r_of_mem[r_of_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_of_wr <= '0;
            r_of_rd <= '0;
            r_ocnt  <= '0;
        end else begin
            r_va <= issue;
            r_vb <= r_va;
            r_vc <= r_vb;
            if (push) begin
                r_of_wr <= r_of_wr + 2'd1;
            end
            if (pop) begin
                r_of_rd <= r_of_rd + 2'd1;
            end
            if (push && !pop) begin
                r_ocnt <= r_ocnt + 3'd1;
            end else if (!push && pop) begin
                r_ocnt <= r_ocnt - 3'd1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (issue && last_j) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_quo  <= QUO_W'(i_job.sum);
                r_dvs  <= SUM_W'(i_job.n);
                r_rem  <= '0;
                r_cnt  <= 6'(QUO_W - 1);
                r_n    <= i_job.n;
                r_bank <= i_job.bank;
            end
            ST_DIV1: begin
                if (r_cnt == 6'd0) begin
                    // Mean square plus epsilon becomes the divisor of 2^48.
                    r_quo <= {1'b1, {(QUO_W-1){1'b0}}};
                    r_dvs <= m_val;
                    r_rem <= '0;
                    r_cnt <= 6'(QUO_W - 1);
                end else begin
                    r_quo <= div_quo;
                    r_rem <= div_rem;
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            ST_DIV2: begin
                if (r_cnt == 6'd0) begin
                    r_sqv  <= {1'b0, div_quo};
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= 6'(RT_W - 1);
                end else begin
                    r_quo <= div_quo;
                    r_rem <= div_rem;
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            ST_SQRT: begin
                r_sqv  <= {r_sqv[47:0], 2'b00};
                r_srem <= sq_rem;
                r_root <= root_nx;
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_scale <= root_nx;
                    r_j     <= '0;
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    r_j <= r_j + ADDR_W'(1);
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase

        r_idx_a  <= r_j;
        r_last_a <= last_j;
        r_p1_b   <= p1_full[40:0];
        r_w_b    <= i_rd_data.w;
        r_idx_b  <= r_idx_a;
        r_last_b <= r_last_a;
        r_p2_c   <= p2_full;
        r_idx_c  <= r_idx_b;
        r_last_c <= r_last_b;
        if (push) begin
            r_of_mem[r_of_wr] <= res_in;
        end
    end

endmodule

### hw/rtl/rms_normalizer.sv
// Input: one element per cycle while the job queue has room and under two vectors are open.
// Output: reads issue only while the result queue has a place for every in-flight read.
// From the closing element to its first result, the back-end sequencer runs two 49-step
// restoring divisions and a 25-step square root, then the read-out takes four stages.
// Synchronous active-low reset clears the accumulator, counters, queues and sets epsilon to 1;
// the element stores are not cleared and need no clearing pass.
module rms_normalizer
    import rmsn_pkg::*;
#(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [EPS_W-1:0] i_cfg_wdata,     // epsilon
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,    // [15:0] x_value, [31:16] w_value
    input  logic             s_axis_tlast,    // last_element
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,    // [15:0] y_value, [21:16] element_index, zeros
    output logic             m_axis_tlast     // last_result
);

    logic [EPS_W-1:0] r_epsilon;
    t_job             front_job;
    logic             front_job_valid;
    logic             queue_ready;
    t_job             queue_job;
    logic             queue_valid;
    logic             back_ready;
    logic             back_done;
    t_rd_req          rd_req;
    t_rd_data         rd_data;
    t_res             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_epsilon <= i_cfg_wdata;
        end
    end

    rmsn_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_x         (s_axis_tdata[15:0]),
        .i_w         (s_axis_tdata[31:16]),
        .i_last      (s_axis_tlast),
        .o_job       (front_job),
        .o_job_valid (front_job_valid),
        .i_job_ready (queue_ready),
        .i_done      (back_done),
        .i_rd_req    (rd_req),
        .o_rd_data   (rd_data)
    );

    rmsn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .i_valid (front_job_valid),
        .o_ready (queue_ready),
        .o_job   (queue_job),
        .o_valid (queue_valid),
        .i_ready (back_ready)
    );

    rmsn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_epsilon   (r_epsilon),
        .i_job       (queue_job),
        .i_job_valid (queue_valid),
        .o_job_ready (back_ready),
        .o_rd_req    (rd_req),
        .i_rd_data   (rd_data),
        .o_done      (back_done),
        .o_res       (res),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, res.idx, res.y};
    assign m_axis_tlast = res.last;

endmodule
